@@ rtl/istd_pkg.sv @@
`timescale 1ns / 1ps
// Package: widths, register indexes, queue entry type and thump constants.
package istd_pkg;

  // Sample and register widths
  localparam int SAMPLE_W = 16;
  localparam int THRESH_W = 34;
  localparam int SQ_W     = 32;
  localparam int CFG_IDX_W = 2;

  // Motion window
  localparam int WINDOW_LEN = 5;
  localparam int WCNT_W     = $clog2(WINDOW_LEN + 1);

  // Decoupling queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_X   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Y   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_OFFSET_Z   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THRESHOLD = 2'd3;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 34'd4034;

  // Stillness mode
  localparam logic [1:0] MODE_RESET = 2'd3;

  // Thump test: 25*a vs 26*prev and 24*prev (1.04 and 0.96 ratios)
  localparam int ACC_W = 22;
  localparam logic signed [ACC_W-1:0] THUMP_DEN = 22'sd25;
  localparam logic signed [ACC_W-1:0] THUMP_HI  = 22'sd26;
  localparam logic signed [ACC_W-1:0] THUMP_LO  = 22'sd24;

  // One classified sample moving from front to back
  typedef struct packed {
    logic                       moving;
    logic signed [SAMPLE_W-1:0] accel_z;
  } q_entry_t;

endpackage

@@ rtl/istd_in_if.sv @@
`timescale 1ns / 1ps
// Interface: input sample channel.
interface istd_in_if;
  import istd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] gyro_x;
  logic signed [SAMPLE_W-1:0] gyro_y;
  logic signed [SAMPLE_W-1:0] gyro_z;
  logic signed [SAMPLE_W-1:0] accel_z;

  modport source (output valid, gyro_x, gyro_y, gyro_z, accel_z, input ready);
  modport sink   (input valid, gyro_x, gyro_y, gyro_z, accel_z, output ready);
endinterface

@@ rtl/istd_out_if.sv @@
`timescale 1ns / 1ps
// Interface: result channel.
interface istd_out_if;
  logic valid;
  logic ready;
  logic is_still;
  logic focus_changed;
  logic thump;

  modport source (output valid, is_still, focus_changed, thump, input ready);
  modport sink   (input valid, is_still, focus_changed, thump, output ready);
endinterface

@@ rtl/istd_front.sv @@
`timescale 1ns / 1ps
// Front: configuration registers, gyro squaring and motion classification.
module istd_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [istd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [istd_pkg::THRESH_W-1:0]     cfg_wdata,
  istd_in_if.sink                           in,
  output logic                              push,
  output istd_pkg::q_entry_t                push_data,
  input  logic                              q_full
);
  import istd_pkg::*;

  logic signed [SAMPLE_W-1:0] gyro_offset_x;
  logic signed [SAMPLE_W-1:0] gyro_offset_y;
  logic signed [SAMPLE_W-1:0] gyro_offset_z;
  logic [THRESH_W-1:0]        motion_threshold;

  logic                       sq_valid;
  logic [SQ_W-1:0]            sq_x;
  logic [SQ_W-1:0]            sq_y;
  logic [SQ_W-1:0]            sq_z;
  logic signed [SAMPLE_W-1:0] sq_accel;

  logic signed [SAMPLE_W:0]     diff_x;
  logic signed [SAMPLE_W:0]     diff_y;
  logic signed [SAMPLE_W:0]     diff_z;
  logic signed [2*SAMPLE_W+1:0] prod_x;
  logic signed [2*SAMPLE_W+1:0] prod_y;
  logic signed [2*SAMPLE_W+1:0] prod_z;
  logic [THRESH_W-1:0]          sum;
  logic                         advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_offset_x    <= '0;
      gyro_offset_y    <= '0;
      gyro_offset_z    <= '0;
      motion_threshold <= THRESH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GYRO_OFFSET_X:    gyro_offset_x    <= cfg_wdata[SAMPLE_W-1:0];
        REG_GYRO_OFFSET_Y:    gyro_offset_y    <= cfg_wdata[SAMPLE_W-1:0];
        REG_GYRO_OFFSET_Z:    gyro_offset_z    <= cfg_wdata[SAMPLE_W-1:0];
        REG_MOTION_THRESHOLD: motion_threshold <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Offset removal and squaring; |diff| <= 65535 so the square fits 32 bits
  always_comb begin
    diff_x = {in.gyro_x[SAMPLE_W-1], in.gyro_x} - {gyro_offset_x[SAMPLE_W-1], gyro_offset_x};
    diff_y = {in.gyro_y[SAMPLE_W-1], in.gyro_y} - {gyro_offset_y[SAMPLE_W-1], gyro_offset_y};
    diff_z = {in.gyro_z[SAMPLE_W-1], in.gyro_z} - {gyro_offset_z[SAMPLE_W-1], gyro_offset_z};
    prod_x = diff_x * diff_x;
    prod_y = diff_y * diff_y;
    prod_z = diff_z * diff_z;
  end

  assign in.ready = !sq_valid || !q_full;
  assign advance  = in.valid && in.ready;
  assign push     = sq_valid && !q_full;

  // Square stage
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (advance) begin
      sq_valid <= 1'b1;
    end else if (push) begin
      sq_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sq_x     <= prod_x[SQ_W-1:0];
      sq_y     <= prod_y[SQ_W-1:0];
      sq_z     <= prod_z[SQ_W-1:0];
      sq_accel <= in.accel_z;
    end
  end

  // Sum and threshold compare
  assign sum = THRESH_W'(sq_x) + THRESH_W'(sq_y) + THRESH_W'(sq_z);
  assign push_data.moving  = (sum > motion_threshold);
  assign push_data.accel_z = sq_accel;

  // A held square stage must not be overwritten while the queue is full
  assert property (@(posedge clk) disable iff (rst)
    (sq_valid && q_full) |=> (sq_valid && $stable(sq_accel)))
    else $error("front: stalled sample lost");
endmodule

@@ rtl/istd_queue.sv @@
`timescale 1ns / 1ps
// Queue: short FIFO of classified samples between front and back.
module istd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  istd_pkg::q_entry_t push_data,
  input  logic               pop,
  output istd_pkg::q_entry_t head,
  output logic               full,
  output logic               empty
);
  import istd_pkg::*;

  q_entry_t            entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue: push while full");
  assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("queue: pop while empty");
  assert property (@(posedge clk) disable iff (rst) count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue: count overflow");
endmodule

@@ rtl/istd_back.sv @@
`timescale 1ns / 1ps
// Back: motion window, stillness mode, thump test and result register.
module istd_back (
  input  logic               clk,
  input  logic               rst,
  input  istd_pkg::q_entry_t head,
  input  logic               empty,
  output logic               pop,
  istd_out_if.source         out
);
  import istd_pkg::*;

  logic [WINDOW_LEN-1:0]      window;
  logic [1:0]                 stillness_mode;
  logic signed [SAMPLE_W-1:0] last_accel_z;

  logic [WINDOW_LEN-1:0]      window_next;
  logic [WCNT_W-1:0]          ones;
  logic                       still;
  logic                       changed;
  logic                       evaluate;
  logic                       thump_hit;
  logic signed [ACC_W-1:0]    cur;
  logic signed [ACC_W-1:0]    hi;
  logic signed [ACC_W-1:0]    lo;

  assign pop = !empty && (!out.valid || out.ready);

  // Window shift and population count
  always_comb begin
    window_next = {window[WINDOW_LEN-2:0], head.moving};
    ones = '0;
    for (int i = 0; i < WINDOW_LEN; i++) begin
      ones = ones + WCNT_W'(window_next[i]);
    end
    still    = !(ones > WCNT_W'(stillness_mode));
    changed  = ({1'b0, still} != stillness_mode);
    evaluate = !changed && still;
  end

  // Thump test against the previous evaluated accel value
  always_comb begin
    cur       = ACC_W'(head.accel_z) * THUMP_DEN;
    hi        = ACC_W'(last_accel_z) * THUMP_HI;
    lo        = ACC_W'(last_accel_z) * THUMP_LO;
    thump_hit = (cur > hi) || (cur < lo);
  end

  // Detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      window         <= '0;
      stillness_mode <= MODE_RESET;
      last_accel_z   <= '0;
    end else if (pop) begin
      window <= window_next;
      if (changed) begin
        stillness_mode <= {1'b0, still};
      end
      if (evaluate) begin
        last_accel_z <= head.accel_z;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out.valid <= 1'b0;
    end else if (pop) begin
      out.valid <= 1'b1;
    end else if (out.ready) begin
      out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out.is_still      <= still;
      out.focus_changed <= changed;
      out.thump         <= evaluate && thump_hit;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out.valid |-> !(out.focus_changed && out.thump))
    else $error("back: thump reported on a focus change");
  assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.thump) |-> out.is_still)
    else $error("back: thump reported while moving");
  assert property (@(posedge clk) disable iff (rst)
    $past(pop) |-> (stillness_mode != MODE_RESET))
    else $error("back: mode not settled after a sample");
endmodule

@@ rtl/imu_stillness_and_thump_detector_top.sv @@
`timescale 1ns / 1ps
// Top level: IMU stillness and thump detector.
//
//   channel  dir  beat payload                           handshake
//   in       in   gyro_x, gyro_y, gyro_z, accel_z        valid/ready
//   out      out  is_still, focus_changed, thump         valid/ready
//   cfg      in   cfg_index, cfg_wdata                   cfg_we, no back-pressure
//
// One sample per cycle while the queue is not full; a beat goes from the square stage
// at acceptance through a queue slot into the result register.
// A four-entry queue separates the squaring front from the window/mode back.
// Reset (rst, synchronous): offsets 0, threshold 4034, window clear, mode 3.
// in.ready drops only when the square stage holds a beat and the queue is full.
module imu_stillness_and_thump_detector_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [istd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [istd_pkg::THRESH_W-1:0]  cfg_wdata,
  istd_in_if.sink                        in,
  istd_out_if.source                     out
);
  import istd_pkg::*;

  logic     push;
  q_entry_t push_data;
  logic     pop;
  q_entry_t head;
  logic     q_full;
  logic     q_empty;

  istd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in        (in),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  istd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  istd_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (q_empty),
    .pop   (pop),
    .out   (out)
  );
endmodule

@@ tb/sv/imu_stillness_and_thump_detector_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for the IMU stillness and thump detector: directed and random samples, scoreboard check.
module imu_stillness_and_thump_detector_top_tb;
  import istd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 290;
  localparam int PRESSURE_AT = 150;
  localparam int PRESSURE_LEN = 200;

  typedef struct packed {
    logic is_still;
    logic focus_changed;
    logic thump;
  } still_result_t;

  // Scoreboard: tracks offsets, threshold, window, mode and last accel
  class still_scoreboard;
    logic signed [SAMPLE_W-1:0] off_x, off_y, off_z;
    logic [THRESH_W-1:0]        thresh;
    logic [WINDOW_LEN-1:0]      window;
    logic [1:0]                 mode;
    logic signed [SAMPLE_W-1:0] prev_az;
    still_result_t              expected_q[$];
    int                         fails;

    function new();
      off_x = '0;
      off_y = '0;
      off_z = '0;
      thresh = THRESH_RESET;
      window = '0;
      mode = MODE_RESET;
      prev_az = '0;
      fails = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [THRESH_W-1:0] data);
      case (idx)
        REG_GYRO_OFFSET_X:    off_x = data[SAMPLE_W-1:0];
        REG_GYRO_OFFSET_Y:    off_y = data[SAMPLE_W-1:0];
        REG_GYRO_OFFSET_Z:    off_z = data[SAMPLE_W-1:0];
        REG_MOTION_THRESHOLD: thresh = data;
        default: ;
      endcase
    endfunction

    function longint sq_diff(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return d * d;
    endfunction

    // Work out the result of one accepted sample beat
    function void note_sample(logic signed [SAMPLE_W-1:0] gx, logic signed [SAMPLE_W-1:0] gy,
                              logic signed [SAMPLE_W-1:0] gz, logic signed [SAMPLE_W-1:0] az);
      longint        sum;
      longint        cur, hi, lo;
      int            cnt;
      still_result_t res;
      sum = sq_diff(gx, off_x) + sq_diff(gy, off_y) + sq_diff(gz, off_z);
      window = {window[WINDOW_LEN-2:0], (sum > longint'(thresh))};
      cnt = $countones(window);
      res = '0;
      res.is_still = (cnt > int'(mode)) ? 1'b0 : 1'b1;
      if ({1'b0, res.is_still} != mode) begin
        res.focus_changed = 1'b1;
        mode = {1'b0, res.is_still};
      end else if (res.is_still) begin
        cur = longint'(az) * longint'(THUMP_DEN);
        hi = longint'(prev_az) * longint'(THUMP_HI);
        lo = longint'(prev_az) * longint'(THUMP_LO);
        res.thump = (cur > hi) || (cur < lo);
        prev_az = az;
      end
      expected_q.push_back(res);
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_result(still_result_t got);
      still_result_t exp;
      string         names[3];
      names = '{"is_still", "focus_changed", "thump"};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %b with nothing pending", $time, got);
        fails++;
        return;
      end
      exp = expected_q.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (exp[2-i] !== got[2-i]) begin
          $display("%0t: %s mismatch: expected %b, actual %b", $time, names[i], exp[2-i],
                   got[2-i]);
          fails++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [THRESH_W-1:0]   cfg_wdata;

  istd_in_if  sample_ch ();
  istd_out_if result_ch ();

  still_scoreboard sb = new();

  int beats_in = 0;
  int cycle_count = 0;
  logic signed [SAMPLE_W-1:0] cur_off[3];
  int gen_prev_az = 0;

  imu_stillness_and_thump_detector_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in        (sample_ch),
    .out       (result_ch)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic signed [SAMPLE_W-1:0] clamp16(int v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[SAMPLE_W-1:0];
  endfunction

  // Gyro value close to the configured offset: counts as still for modest thresholds
  function automatic logic signed [SAMPLE_W-1:0] gyro_near(logic signed [SAMPLE_W-1:0] off);
    if ($urandom_range(0, 9) < 3) return off;
    return clamp16(int'(off) + int'($urandom_range(0, 90)) - 45);
  endfunction

  // Accel value around the 4 percent thump boundaries of the previous one
  function automatic logic signed [SAMPLE_W-1:0] accel_near(int prev);
    int span;
    span = ((prev < 0) ? -prev : prev) / 16 + 2;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return clamp16(prev + int'($urandom_range(0, 2 * span)) - span);
      6:                return clamp16(prev * 26 / 25);
      7:                return clamp16(prev * 24 / 25);
      default:          return 16'($urandom());
    endcase
  endfunction

  // Register write on the config port; block is idle here
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [THRESH_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic configure(logic signed [SAMPLE_W-1:0] ox, logic signed [SAMPLE_W-1:0] oy,
                           logic signed [SAMPLE_W-1:0] oz, logic [THRESH_W-1:0] th);
    write_reg(REG_GYRO_OFFSET_X, {{(THRESH_W-SAMPLE_W){ox[SAMPLE_W-1]}}, ox});
    write_reg(REG_GYRO_OFFSET_Y, {{(THRESH_W-SAMPLE_W){oy[SAMPLE_W-1]}}, oy});
    write_reg(REG_GYRO_OFFSET_Z, {{(THRESH_W-SAMPLE_W){oz[SAMPLE_W-1]}}, oz});
    write_reg(REG_MOTION_THRESHOLD, th);
    cur_off = '{ox, oy, oz};
  endtask

  // Offer one sample beat and hold it until accepted
  task automatic send(logic signed [SAMPLE_W-1:0] gx, logic signed [SAMPLE_W-1:0] gy,
                      logic signed [SAMPLE_W-1:0] gz, logic signed [SAMPLE_W-1:0] az);
    @(negedge clk);
    sample_ch.valid <= 1'b1;
    sample_ch.gyro_x <= gx;
    sample_ch.gyro_y <= gy;
    sample_ch.gyro_z <= gz;
    sample_ch.accel_z <= az;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(gx, gy, gz, az);
    beats_in++;
  endtask

  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      sample_ch.valid <= 1'b0;
    end
  endtask

  // Wait until every expected result is back, then a few more cycles
  task automatic drain();
    idle(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random part: segments of still runs, moving runs and noise
  task automatic run_random(int n_items);
    int   left, seg_len, kind;
    bit   steady, moving;
    logic signed [SAMPLE_W-1:0] gx, gy, gz, az;
    left = n_items;
    while (left > 0) begin
      seg_len = $urandom_range(3, 30);
      kind = $urandom_range(0, 9);
      steady = ($urandom_range(0, 2) == 0);
      for (int j = 0; j < seg_len && left > 0; j++) begin
        if (kind < 7) moving = ($urandom_range(0, 9) == 0);
        else if (kind < 9) moving = 1'b1;
        else moving = 1'($urandom_range(0, 1));
        if (moving) begin
          gx = 16'($urandom());
          gy = 16'($urandom());
          gz = 16'($urandom());
        end else begin
          gx = gyro_near(cur_off[0]);
          gy = gyro_near(cur_off[1]);
          gz = gyro_near(cur_off[2]);
        end
        az = (kind == 9) ? 16'($urandom()) : accel_near(gen_prev_az);
        gen_prev_az = int'(az);
        send(gx, gy, gz, az);
        left--;
        if (!steady) begin
          case ($urandom_range(0, 19))
            0:                 idle($urandom_range(8, 40));
            1, 2, 3, 4, 5:     idle($urandom_range(1, 3));
            default: ;
          endcase
        end
      end
    end
  endtask

  // Result side: random stalls, steady stretches, one long hold-off
  initial begin
    int  stall_left;
    int  run_left;
    bit  steady;
    bit  pressure_done;
    stall_left = 0;
    run_left = 0;
    steady = 1'b0;
    pressure_done = 1'b0;
    result_ch.ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ch.ready <= 1'b0;
        stall_left--;
      end else if (!pressure_done && beats_in >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        stall_left = PRESSURE_LEN - 1;
        result_ch.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          run_left = $urandom_range(10, 80);
          steady = ($urandom_range(0, 2) == 0);
        end
        run_left--;
        if (!steady && $urandom_range(0, 3) == 0) begin
          stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
          result_ch.ready <= 1'b0;
        end else begin
          result_ch.ready <= 1'b1;
        end
      end
    end
  end

  // Sample result beats at the rising edge
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result('{result_ch.is_still, result_ch.focus_changed, result_ch.thump});
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  // Main sequence
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    sample_ch.valid = 1'b0;
    sample_ch.gyro_x = '0;
    sample_ch.gyro_y = '0;
    sample_ch.gyro_z = '0;
    sample_ch.accel_z = '0;
    cur_off = '{16'sd0, 16'sd0, 16'sd0};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    configure(16'sd0, 16'sd0, 16'sd0, THRESH_RESET);

    // Directed: first tick focus change, thump bounds, accel extremes
    send(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send(16'sd0, 16'sd0, 16'sd0, 16'sd1000);
    send(16'sd0, 16'sd0, 16'sd0, 16'sd1040);
    send(16'sd0, 16'sd0, 16'sd0, 16'sd960);
    send(16'sd0, 16'sd0, 16'sd0, -16'sd32768);
    send(16'sd0, 16'sd0, 16'sd0, 16'sd32767);
    send(16'sd0, 16'sd0, 16'sd0, -16'sd1000);
    send(16'sd0, 16'sd0, 16'sd0, -16'sd1040);
    send(16'sd0, 16'sd0, 16'sd0, -16'sd1000);
    // Sum exactly at threshold stays still, a sum three above it is moving
    send(16'sd63, 16'sd8, 16'sd1, -16'sd960);
    send(16'sd63, 16'sd8, 16'sd2, -16'sd960);
    // Gyro extremes: moving ticks push the mode to moving
    send(16'sd32767, -16'sd32768, 16'sd32767, 16'sd0);
    send(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd5);
    send(16'sd32767, 16'sd32767, 16'sd32767, -16'sd5);
    send(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd0);
    // Quiet ticks clear the window and return to still
    repeat (6) send(16'sd1, -16'sd1, 16'sd0, -16'sd2000);
    send(16'sd0, 16'sd0, 16'sd0, -16'sd2100);
    send(16'sd0, 16'sd0, 16'sd0, -16'sd1900);
    gen_prev_az = -1900;

    run_random(PHASE_ITEMS);

    // Extreme offsets, zero threshold
    drain();
    configure(16'sd32767, -16'sd32768, 16'sd32767, '0);
    run_random(PHASE_ITEMS);

    // Opposite extreme offsets, full threshold
    drain();
    configure(-16'sd32768, 16'sd32767, -16'sd32768, {THRESH_W{1'b1}});
    run_random(PHASE_ITEMS);

    // Random offsets, moderate thresholds
    drain();
    configure(16'($urandom()), 16'($urandom()), 16'($urandom()),
              THRESH_W'($urandom_range(0, 20000)));
    run_random(PHASE_ITEMS);

    drain();
    configure(16'($urandom()), 16'($urandom()), 16'($urandom()),
              THRESH_W'($urandom_range(0, 1 << 20)));
    run_random(PHASE_ITEMS);

    drain();
    if (sb.fails == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ imu_stillness_and_thump_detector_top.f @@
rtl/istd_pkg.sv
rtl/istd_in_if.sv
rtl/istd_out_if.sv
rtl/istd_front.sv
rtl/istd_queue.sv
rtl/istd_back.sv
rtl/imu_stillness_and_thump_detector_top.sv
tb/sv/imu_stillness_and_thump_detector_top_tb.sv
